// File: design/hpt_pkg.sv
// Shared types and constants for the homogeneous point transform.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package hpt_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int COORD_WIDTH_DEF = 32;

    localparam int FIELD_W     = 32;
    localparam int ENTRY_W     = 32;
    localparam int MAT_ENTRIES = 16;
    localparam int CFG_W       = 64;
    localparam int NUM_CFG     = 8;
    localparam int CFG_IDX_W   = 4;
    localparam int QUEUE_DEPTH = 4;

    // How the back end forms the final coordinates of an item.
    localparam logic [1:0] MODE_PASS = 2'd0;
    localparam logic [1:0] MODE_ZERO = 2'd1;
    localparam logic [1:0] MODE_DIV  = 2'd2;

    typedef logic [MAT_ENTRIES-1:0][ENTRY_W-1:0] mat_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] coord_x;
        logic signed [FIELD_W-1:0] coord_y;
        logic signed [FIELD_W-1:0] coord_z;
        logic                      is_point;
    } item_t;

endpackage

`default_nettype wire

// File: design/hpt_coord_if.sv
// Input channel of the point transform: valid/ready with one coordinate.
// Depends on hpt_pkg for the field width.
`default_nettype none

interface hpt_coord_if;
    logic                              valid;
    logic                              ready;
    logic signed [hpt_pkg::FIELD_W-1:0] coord_x;
    logic signed [hpt_pkg::FIELD_W-1:0] coord_y;
    logic signed [hpt_pkg::FIELD_W-1:0] coord_z;
    logic                              is_point;

    modport source (output valid, coord_x, coord_y, coord_z, is_point, input ready);
    modport sink   (input valid, coord_x, coord_y, coord_z, is_point, output ready);
endinterface

`default_nettype wire

// File: design/hpt_result_if.sv
// Output channel of the point transform: valid/ready with one result.
// Depends on hpt_pkg for the field width.
`default_nettype none

interface hpt_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [hpt_pkg::FIELD_W-1:0] out_x;
    logic signed [hpt_pkg::FIELD_W-1:0] out_y;
    logic signed [hpt_pkg::FIELD_W-1:0] out_z;
    logic                              w_zero;

    modport source (output valid, out_x, out_y, out_z, w_zero, input ready);
    modport sink   (input valid, out_x, out_y, out_z, w_zero, output ready);
endinterface

`default_nettype wire

// File: design/homogeneous_point_transform_top.sv
// Throughput: one transaction per cycle while the result is not stalled, set by the fully
// pipelined back end in which the perspective divide resolves one quotient bit per stage
// for all three rows.
// Reset (rst_n, asynchronous, active low) empties every stage and the queue and
// loads the identity matrix; it needs no clearing pass.
// Depends on hpt_pkg, both channel interfaces, hpt_front, hpt_queue and hpt_back.
`default_nettype none

module homogeneous_point_transform_top #(
    parameter int FRAC_BITS   = hpt_pkg::FRAC_BITS_DEF,
    parameter int COORD_WIDTH = hpt_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [hpt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [hpt_pkg::CFG_W-1:0]     cfg_wdata,
    hpt_coord_if.sink                          coord_ch,
    hpt_result_if.source                       result_ch
);

    localparam int NCFG = hpt_pkg::NUM_CFG;
    localparam int SEL_W = $clog2(NCFG);
    localparam int EW   = hpt_pkg::ENTRY_W;

    // One in Q format, placed in the low or high half of a register pair.
    localparam logic [EW-1:0]                ONE_Q   = EW'(1) << FRAC_BITS;
    localparam logic [hpt_pkg::CFG_W-1:0]    ONE_LO  = {{EW{1'b0}}, ONE_Q};
    localparam logic [hpt_pkg::CFG_W-1:0]    ONE_HI  = {ONE_Q, {EW{1'b0}}};

    // Matrix store. Each register pair holds two column-major entries, the lower index
    // in the low half. Reset loads the identity, so the diagonal entries 0, 5, 10 and
    // 15 hold one and everything else is zero. Writes past the last pair are dropped.
    // Software must write only with no transaction in flight; the block does not check it.
    logic [hpt_pkg::CFG_W-1:0] pair_reg [NCFG];
    hpt_pkg::mat_t             mat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_reg <= '{0: ONE_LO, 2: ONE_HI, 5: ONE_LO, 7: ONE_HI, default: '0};
        end
        else if (cfg_we && (cfg_index < hpt_pkg::CFG_IDX_W'(NCFG)))
        begin
            pair_reg[cfg_index[SEL_W-1:0]] <= cfg_wdata;
        end
    end

    always_comb
    begin
        for (int k = 0; k < NCFG; k++)
        begin
            mat[2 * k]     = pair_reg[k][EW-1:0];
            mat[2 * k + 1] = pair_reg[k][2*EW-1:EW];
        end
    end

    // The front end registers each transaction and sign-extends the coordinates from
    // the working width; the queue behind it lets the front keep accepting while the
    // back end is held by a stalled result.
    hpt_pkg::item_t f_item;
    logic           f_valid;
    logic           f_ready;
    hpt_pkg::item_t q_item;
    logic           q_valid;
    logic           q_ready;

    hpt_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .coord_ch   (coord_ch),
        .item       (f_item),
        .item_valid (f_valid),
        .item_ready (f_ready)
    );

    hpt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (f_item),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .pop_item   (q_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready)
    );

    // The back end forms the four row sums, then for points either passes them through
    // (w exactly one), saturates them (w zero) or divides them by w, and saturates.
    // The whole pipeline advances together whenever its output register can move.
    hpt_back #(
        .FRAC_BITS   (FRAC_BITS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .mat        (mat),
        .item       (q_item),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .result_ch  (result_ch)
    );

endmodule

`default_nettype wire

// File: design/hpt_front.sv
// Front end: takes coordinate transactions and narrows them to the working width.
// Depends on hpt_pkg and hpt_coord_if.
`default_nettype none

module hpt_front #(
    parameter int COORD_WIDTH = hpt_pkg::COORD_WIDTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    hpt_coord_if.sink          coord_ch,
    output hpt_pkg::item_t     item,
    output logic               item_valid,
    input  wire logic          item_ready
);

    logic           valid_reg;
    logic           valid_next;
    hpt_pkg::item_t item_reg;
    hpt_pkg::item_t item_next;
    logic           take;

    assign coord_ch.ready = !valid_reg || item_ready;
    assign take           = coord_ch.valid && coord_ch.ready;
    assign valid_next     = take || (valid_reg && !item_ready);

    // Only the low COORD_WIDTH bits of each coordinate count; they are sign-extended.
    always_comb
    begin
        item_next.coord_x  = hpt_pkg::FIELD_W'($signed(coord_ch.coord_x[COORD_WIDTH-1:0]));
        item_next.coord_y  = hpt_pkg::FIELD_W'($signed(coord_ch.coord_y[COORD_WIDTH-1:0]));
        item_next.coord_z  = hpt_pkg::FIELD_W'($signed(coord_ch.coord_z[COORD_WIDTH-1:0]));
        item_next.is_point = coord_ch.is_point;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

`default_nettype wire

// File: design/hpt_queue.sv
// Short queue between the front end and the arithmetic back end.
// Depends on hpt_pkg for the item type and the depth.
`default_nettype none

module hpt_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire hpt_pkg::item_t push_item,
    input  wire logic           push_valid,
    output logic                push_ready,
    output hpt_pkg::item_t      pop_item,
    output logic                pop_valid,
    input  wire logic           pop_ready
);

    localparam int DEPTH = hpt_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    hpt_pkg::item_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// File: design/hpt_back.sv
// Back end: matrix multiply, row sums, perspective divide and saturation.
// Depends on hpt_pkg and hpt_result_if.
`default_nettype none

module hpt_back #(
    parameter int FRAC_BITS   = hpt_pkg::FRAC_BITS_DEF,
    parameter int COORD_WIDTH = hpt_pkg::COORD_WIDTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire hpt_pkg::mat_t  mat,
    input  wire hpt_pkg::item_t item,
    input  wire logic           item_valid,
    output logic                item_ready,
    hpt_result_if.source        result_ch
);

    localparam int EW  = hpt_pkg::ENTRY_W;
    localparam int CW  = COORD_WIDTH;
    localparam int NW  = (CW > FRAC_BITS) ? CW : FRAC_BITS;
    localparam int PW  = NW + EW;
    localparam int SW  = PW + 2;
    localparam int RW  = SW - FRAC_BITS;
    localparam int XW  = RW + CW + FRAC_BITS;
    localparam int OW  = hpt_pkg::FIELD_W;

    localparam logic signed [RW-1:0] ONE_W = RW'(1) <<< FRAC_BITS;
    localparam logic signed [CW-1:0] CMAX  = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN  = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0]        MAXU  = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0]        MINU  = {1'b1, {(CW-1){1'b0}}};

    logic adv;

    // Stage 1: products.
    logic                 s1_valid_reg;
    logic                 s1_pt_reg;
    logic signed [PW-1:0] s1_prod_reg  [4][4];
    logic signed [PW-1:0] s1_prod_next [4][4];

    // Stage 2: rows floored to FRAC_BITS fraction bits.
    logic                 s2_valid_reg;
    logic                 s2_pt_reg;
    logic signed [RW-1:0] s2_row_reg  [4];
    logic signed [RW-1:0] s2_row_next [4];

    // Stage 3: classification and magnitudes.
    logic                 s3_valid_reg;
    logic                 s3_div_reg;
    logic                 s3_div_next;
    logic                 s3_wz_reg;
    logic                 s3_wz_next;
    logic [RW-1:0]        s3_d_reg;
    logic [RW-1:0]        s3_d_next;
    logic [RW-1:0]        s3_mag_reg  [3];
    logic [RW-1:0]        s3_mag_next [3];
    logic                 s3_neg_reg  [3];
    logic                 s3_neg_next [3];
    logic signed [CW-1:0] s3_fin_reg  [3];
    logic signed [CW-1:0] s3_fin_next [3];

    // Divider pipeline: index 0 is the set-up stage, CW one quotient bit each.
    logic                 dv_valid_reg [CW+1];
    logic                 dv_div_reg   [CW+1];
    logic                 dv_wz_reg    [CW+1];
    logic [RW-1:0]        dv_d_reg     [CW+1];
    logic [XW-1:0]        dv_rem_reg   [CW+1][3];
    logic [CW-1:0]        dv_q_reg     [CW+1][3];
    logic                 dv_ovf_reg   [CW+1][3];
    logic                 dv_neg_reg   [CW+1][3];
    logic signed [CW-1:0] dv_fin_reg   [CW+1][3];

    // Output register.
    logic                 out_valid_reg;
    logic signed [OW-1:0] out_c_reg  [3];
    logic signed [OW-1:0] out_c_next [3];
    logic                 out_wz_reg;

    assign adv        = !out_valid_reg || result_ch.ready;
    assign item_ready = adv;

    always_comb
    begin
        logic signed [CW-1:0]    v [3];
        logic signed [EW-1:0]    m;
        logic signed [EW+CW-1:0] p;
        v[0] = item.coord_x[CW-1:0];
        v[1] = item.coord_y[CW-1:0];
        v[2] = item.coord_z[CW-1:0];
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                m = mat[r + 4 * c];
                p = m * v[c];
                s1_prod_next[r][c] = PW'(p);
            end
            m = mat[r + 12];
            s1_prod_next[r][3] = item.is_point ? (PW'(m) <<< FRAC_BITS) : '0;
        end
    end

    always_comb
    begin
        logic signed [SW-1:0] sum;
        for (int r = 0; r < 4; r++)
        begin
            sum = SW'(s1_prod_reg[r][0]) + SW'(s1_prod_reg[r][1])
                + SW'(s1_prod_reg[r][2]) + SW'(s1_prod_reg[r][3]);
            s2_row_next[r] = RW'(sum >>> FRAC_BITS);
        end
    end

    always_comb
    begin
        logic signed [RW-1:0] w;
        logic                 w_one;
        w           = s2_row_reg[3];
        w_one       = (w == ONE_W);
        s3_wz_next  = s2_pt_reg && (w == '0);
        s3_div_next = s2_pt_reg && !w_one && !s3_wz_next;
        s3_d_next   = w[RW-1] ? RW'(-w) : RW'(w);
        for (int i = 0; i < 3; i++)
        begin
            s3_mag_next[i] = s2_row_reg[i][RW-1] ? RW'(-s2_row_reg[i]) : RW'(s2_row_reg[i]);
            s3_neg_next[i] = s2_row_reg[i][RW-1] ^ w[RW-1];
            if (s3_wz_next)
            begin
                s3_fin_next[i] = s2_row_reg[i][RW-1] ? CMIN : CMAX;
            end
            else if (s2_row_reg[i] > RW'(CMAX))
            begin
                s3_fin_next[i] = CMAX;
            end
            else if (s2_row_reg[i] < RW'(CMIN))
            begin
                s3_fin_next[i] = CMIN;
            end
            else
            begin
                s3_fin_next[i] = CW'(s2_row_reg[i]);
            end
        end
    end

    always_comb
    begin
        logic [CW-1:0] q;
        for (int i = 0; i < 3; i++)
        begin
            q = dv_q_reg[CW][i];
            if (!dv_div_reg[CW])
            begin
                out_c_next[i] = OW'(dv_fin_reg[CW][i]);
            end
            else if (dv_neg_reg[CW][i])
            begin
                out_c_next[i] = (dv_ovf_reg[CW][i] || q > MINU) ? OW'(CMIN)
                                                                : OW'(signed'(CW'(-q)));
            end
            else
            begin
                out_c_next[i] = (dv_ovf_reg[CW][i] || q > MAXU) ? OW'(CMAX)
                                                                : OW'(signed'(q));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            dv_valid_reg  <= '{default: 1'b0};
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= item_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            dv_valid_reg[0] <= s3_valid_reg;
            for (int g = 0; g < CW; g++)
            begin
                dv_valid_reg[g+1] <= dv_valid_reg[g];
            end
            out_valid_reg <= dv_valid_reg[CW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pt_reg   <= item.is_point;
            s1_prod_reg <= s1_prod_next;
            s2_pt_reg   <= s1_pt_reg;
            s2_row_reg  <= s2_row_next;
            s3_div_reg  <= s3_div_next;
            s3_wz_reg   <= s3_wz_next;
            s3_d_reg    <= s3_d_next;
            s3_mag_reg  <= s3_mag_next;
            s3_neg_reg  <= s3_neg_next;
            s3_fin_reg  <= s3_fin_next;
            dv_div_reg[0] <= s3_div_reg;
            dv_wz_reg[0]  <= s3_wz_reg;
            dv_d_reg[0]   <= s3_d_reg;
            for (int i = 0; i < 3; i++)
            begin
                dv_rem_reg[0][i] <= XW'(s3_mag_reg[i]) << FRAC_BITS;
                dv_ovf_reg[0][i] <= (XW'(s3_mag_reg[i]) << FRAC_BITS)
                                    >= (XW'(s3_d_reg) << CW);
                dv_q_reg[0][i]   <= '0;
                dv_neg_reg[0][i] <= s3_neg_reg[i];
                dv_fin_reg[0][i] <= s3_fin_reg[i];
            end
            out_c_reg  <= out_c_next;
            out_wz_reg <= dv_wz_reg[CW];
        end
    end

    // One restoring step per stage; quotient bits come out most significant first.
    for (genvar g = 0; g < CW; g++)
    begin : g_div
        logic [XW-1:0] ds;
        assign ds = XW'(dv_d_reg[g]) << (CW - 1 - g);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_div_reg[g+1] <= dv_div_reg[g];
                dv_wz_reg[g+1]  <= dv_wz_reg[g];
                dv_d_reg[g+1]   <= dv_d_reg[g];
                for (int i = 0; i < 3; i++)
                begin
                    if (dv_rem_reg[g][i] >= ds)
                    begin
                        dv_rem_reg[g+1][i] <= dv_rem_reg[g][i] - ds;
                        dv_q_reg[g+1][i]   <= {dv_q_reg[g][i][CW-2:0], 1'b1};
                    end
                    else
                    begin
                        dv_rem_reg[g+1][i] <= dv_rem_reg[g][i];
                        dv_q_reg[g+1][i]   <= {dv_q_reg[g][i][CW-2:0], 1'b0};
                    end
                    dv_ovf_reg[g+1][i] <= dv_ovf_reg[g][i];
                    dv_neg_reg[g+1][i] <= dv_neg_reg[g][i];
                    dv_fin_reg[g+1][i] <= dv_fin_reg[g][i];
                end
            end
        end
    end

    assign result_ch.valid  = out_valid_reg;
    assign result_ch.out_x  = out_c_reg[0];
    assign result_ch.out_y  = out_c_reg[1];
    assign result_ch.out_z  = out_c_reg[2];
    assign result_ch.w_zero = out_wz_reg;

endmodule

`default_nettype wire

// File: design/hpt_checker.sv
// Port-level checks for the point transform, bound to the top level.
// Depends on hpt_pkg and the top level's ports.
`default_nettype none

module hpt_checker #(
    parameter int COORD_WIDTH = hpt_pkg::COORD_WIDTH_DEF
) (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                res_valid,
    input wire logic                                res_ready,
    input wire logic signed [hpt_pkg::FIELD_W-1:0]  res_x,
    input wire logic signed [hpt_pkg::FIELD_W-1:0]  res_y,
    input wire logic signed [hpt_pkg::FIELD_W-1:0]  res_z,
    input wire logic                                res_wz
);

    localparam logic signed [hpt_pkg::FIELD_W-1:0] SMAX =
        hpt_pkg::FIELD_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [hpt_pkg::FIELD_W-1:0] SMIN =
        hpt_pkg::FIELD_W'(-(64'sd1 <<< (COORD_WIDTH - 1)));

    a_valid_hold : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result valid dropped before the transaction completed");

    a_payload_hold : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_x) && $stable(res_y) && $stable(res_z)
                                    && $stable(res_wz))
        else $error("result payload changed while stalled");

    a_zero_w_saturates : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_wz |-> (res_x == SMAX || res_x == SMIN)
                             && (res_y == SMAX || res_y == SMIN)
                             && (res_z == SMAX || res_z == SMIN))
        else $error("zero w result not saturated");

    a_quiet_in_reset : assert property (@(posedge clk)
        !rst_n |-> !res_valid)
        else $error("result offered during reset");

endmodule

bind homogeneous_point_transform_top hpt_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_hpt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result_ch.valid),
    .res_ready (result_ch.ready),
    .res_x     (result_ch.out_x),
    .res_y     (result_ch.out_y),
    .res_z     (result_ch.out_z),
    .res_wz    (result_ch.w_zero)
);

`default_nettype wire
